/* rtl/core/wbps_pkg.sv */
// Shared types and constants for the wildcard byte pattern scanner.
// Used by every module under rtl/core; depends on nothing.
package wbps_pkg;

	localparam int MAX_PATTERN_BYTES_DEF = 16;
	localparam int OFFSET_WIDTH_DEF      = 32;

	// Signature bytes that the pattern registers can hold; later positions are wildcards.
	localparam int SIG_BYTES   = 16;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int MATCH_OFS_W = 32;
	localparam int PLEN_W      = 5;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_HIGH = 3'd1,
		REG_CARE_MASK    = 3'd2,
		REG_PATTERN_LEN  = 3'd3
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_of_region;
	} in_item_t;

	typedef struct packed {
		logic                   hit;
		logic [MATCH_OFS_W-1:0] match_offset;
	} out_item_t;

	// Per-cell view of the signature, aligned to the cell's window position.
	typedef struct packed {
		logic [7:0] sig_byte;
		logic       care;
		logic       at_len_end;
	} cell_cfg_t;

	typedef struct packed {
		logic ok;
		logic tail_valid;
	} cell_stat_t;

endpackage

/* rtl/core/wbps_cell.sv */
// One window cell: holds a byte and its valid bit, shifts them to the next cell.
// Depends on wbps_pkg.
module wbps_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift,
	input  logic [7:0]             byte_in,
	input  logic                   valid_in,
	input  wbps_pkg::cell_cfg_t    cfg,
	output logic [7:0]             byte_out,
	output logic                   valid_out,
	output wbps_pkg::cell_stat_t   stat
);

	logic [7:0] byte_q;
	logic       valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out        = byte_q;
	assign valid_out       = valid_q;
	// A wildcard or unused position always passes.
	assign stat.ok         = !cfg.care || (byte_q == cfg.sig_byte);
	assign stat.tail_valid = cfg.at_len_end && valid_q;

endmodule

/* rtl/core/wbps_align.sv */
// Aligns the signature registers to window positions for the effective length.
// Depends on wbps_pkg.
module wbps_align #(
	parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF
) (
	input  logic [wbps_pkg::CFG_DATA_W-1:0] pattern_low,
	input  logic [wbps_pkg::CFG_DATA_W-1:0] pattern_high,
	input  logic [wbps_pkg::SIG_BYTES-1:0]  care_mask,
	input  logic [wbps_pkg::PLEN_W-1:0]     pattern_length,
	output logic [wbps_pkg::PLEN_W-1:0]     len_m1,
	output wbps_pkg::cell_cfg_t             cell_cfg [MAX_PATTERN_BYTES]
);

	logic [8*wbps_pkg::SIG_BYTES-1:0] sig_all;
	logic [wbps_pkg::PLEN_W-1:0]      eff_len;

	assign sig_all = {pattern_high, pattern_low};

	// Clamp the length to 1..MAX_PATTERN_BYTES.
	always_comb begin
		if (pattern_length == '0) begin
			eff_len = wbps_pkg::PLEN_W'(1);
		end else if ({2'b00, pattern_length} > 7'(MAX_PATTERN_BYTES)) begin
			eff_len = wbps_pkg::PLEN_W'(MAX_PATTERN_BYTES);
		end else begin
			eff_len = pattern_length;
		end
		len_m1 = eff_len - wbps_pkg::PLEN_W'(1);
	end

	// Window position j (0 newest) meets signature byte len-1-j.
	always_comb begin
		logic [6:0] kk;
		logic       in_use;
		for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
			kk                     = {2'b00, len_m1} - 7'(j);
			in_use                 = 7'(j) <= {2'b00, len_m1};
			cell_cfg[j].sig_byte   = sig_all[8*kk[3:0] +: 8];
			cell_cfg[j].care       = in_use && (kk < 7'(wbps_pkg::SIG_BYTES))
			                         && care_mask[kk[3:0]];
			cell_cfg[j].at_len_end = in_use && (kk == 7'd0);
		end
	end

endmodule

/* rtl/core/wildcard_byte_pattern_scan.sv */
// Wildcard byte signature scanner: top level.
// A byte is accepted into the window and stage 1, evaluated there, then its result is registered.
// Throughput: one byte per cycle while in_ready is high; the window cells shift on each accepted byte.
// While a result item is stalled, bytes that cause no result keep flowing; a byte that
// would cause one waits in the evaluation stage and in_ready drops until the sink takes it.
// Reset (arst_n low) clears the window valid bits, offset counter, match flag,
// pipeline valids, and returns the registers to their defaults (length 1).
module wildcard_byte_pattern_scan #(
	parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF,
	parameter int OFFSET_WIDTH      = wbps_pkg::OFFSET_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// byte stream
	input  logic                               in_valid,
	output logic                               in_ready,
	input  wbps_pkg::in_item_t                 in_item,
	// result stream
	output logic                               out_valid,
	input  logic                               out_ready,
	output wbps_pkg::out_item_t                out_item,
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wbps_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// Configuration registers
	logic [wbps_pkg::CFG_DATA_W-1:0] pat_lo_q;
	logic [wbps_pkg::CFG_DATA_W-1:0] pat_hi_q;
	logic [wbps_pkg::SIG_BYTES-1:0]  care_q;
	logic [wbps_pkg::PLEN_W-1:0]     plen_q;

	// Stage 1: the byte just shifted into the window, awaiting evaluation
	logic                    valid_s1;
	logic                    last_s1;
	logic [OFFSET_WIDTH-1:0] offset_s1;

	logic [OFFSET_WIDTH-1:0] count_q;
	logic                    matched_q;
	logic                    out_valid_q;
	wbps_pkg::out_item_t     out_item_q;

	logic                    accept;
	logic                    eval_go;
	logic                    emit;
	logic                    match;
	logic [OFFSET_WIDTH-1:0] this_ofs;
	logic [OFFSET_WIDTH-1:0] start_ofs;
	logic [OFFSET_WIDTH+wbps_pkg::MATCH_OFS_W-1:0] start_ext;
	logic [wbps_pkg::PLEN_W-1:0] len_m1;

	logic [7:0]                   win_byte  [MAX_PATTERN_BYTES];
	logic [MAX_PATTERN_BYTES-1:0] win_valid;
	wbps_pkg::cell_cfg_t          ccfg      [MAX_PATTERN_BYTES];
	wbps_pkg::cell_stat_t         cstat     [MAX_PATTERN_BYTES];

	// Register writes are always taken; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			care_q   <= '0;
			plen_q   <= wbps_pkg::PLEN_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				wbps_pkg::REG_PATTERN_LOW:  pat_lo_q <= cfg_data;
				wbps_pkg::REG_PATTERN_HIGH: pat_hi_q <= cfg_data;
				wbps_pkg::REG_CARE_MASK:    care_q   <= cfg_data[wbps_pkg::SIG_BYTES-1:0];
				wbps_pkg::REG_PATTERN_LEN:  plen_q   <= cfg_data[wbps_pkg::PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	wbps_align #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
	) u_align (
		.pattern_low   (pat_lo_q),
		.pattern_high  (pat_hi_q),
		.care_mask     (care_q),
		.pattern_length(plen_q),
		.len_m1        (len_m1),
		.cell_cfg      (ccfg)
	);

	// Window chain: cell 0 takes the new byte, each cell hands its byte onward.
	// The first byte after a region's last byte drops all older valid bits.
	for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
		logic [7:0] byte_in;
		logic       valid_in;
		if (j == 0) begin : g_head
			assign byte_in  = in_item.data_byte;
			assign valid_in = 1'b1;
		end else begin : g_body
			assign byte_in  = win_byte[j-1];
			assign valid_in = win_valid[j-1] && !last_s1;
		end
		wbps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (accept),
			.byte_in  (byte_in),
			.valid_in (valid_in),
			.cfg      (ccfg[j]),
			.byte_out (win_byte[j]),
			.valid_out(win_valid[j]),
			.stat     (cstat[j])
		);
	end

	// Full match: every cell passes and the window is filled up to the length.
	always_comb begin
		logic all_ok;
		logic filled;
		all_ok = 1'b1;
		filled = 1'b0;
		for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
			all_ok = all_ok & cstat[j].ok;
			filled = filled | cstat[j].tail_valid;
		end
		match = all_ok && filled;
	end

	// One result per region: the first match, else "not found" on the last byte.
	assign emit     = valid_s1 && !matched_q && (match || last_s1);
	assign eval_go  = valid_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || eval_go;
	assign accept   = in_valid && in_ready;

	// Offset restarts at zero with the first byte of a new region.
	assign this_ofs  = last_s1 ? '0 : count_q;
	assign start_ofs = offset_s1 - {{(OFFSET_WIDTH-wbps_pkg::PLEN_W){1'b0}}, len_m1};
	assign start_ext = {{wbps_pkg::MATCH_OFS_W{1'b0}}, start_ofs};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			last_s1     <= 1'b0;
			count_q     <= '0;
			matched_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Advance the byte stage.
			if (accept) begin
				valid_s1 <= 1'b1;
				last_s1  <= in_item.last_of_region;
				count_q  <= this_ofs + OFFSET_WIDTH'(1);
			end else if (eval_go) begin
				valid_s1 <= 1'b0;
			end
			// Hold the match flag until the region ends.
			if (eval_go) begin
				matched_q <= last_s1 ? 1'b0 : (matched_q || match);
			end
			if (eval_go && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			offset_s1 <= this_ofs;
		end
		if (eval_go && emit) begin
			out_item_q.hit          <= match;
			out_item_q.match_offset <= match ? start_ext[wbps_pkg::MATCH_OFS_W-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

/* rtl/core/wbps_checker.sv */
// Port-level checks for the wildcard byte pattern scanner, bound to the top level.
// Depends on wbps_pkg and wildcard_byte_pattern_scan.
module wbps_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  wbps_pkg::in_item_t  in_item,
	input  logic                out_valid,
	input  logic                out_ready,
	input  wbps_pkg::out_item_t out_item
);

	// A waiting byte holds.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_item))
		else $error("byte item changed while waiting");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	// A "not found" result carries a zero offset.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.hit |-> out_item.match_offset == '0)
		else $error("not-found item with nonzero offset");

	// Input backpressure only comes from a stalled result.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without a stalled result");

	// A fresh result must trace back to an earlier accepted byte.
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result item without a byte two cycles earlier");

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_item  (in_item),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item (out_item)
);
